/* hdl/nfc_pkg.sv */
`timescale 1ns / 1ps

package nfc_pkg;

    localparam int FRAME_MAX_DEFAULT = 259;

    localparam int QUEUE_DEPTH = 4;
    localparam int LEVEL_W     = $clog2(QUEUE_DEPTH + 1);

    localparam logic [15:0] CRC_INIT = 16'h6363;
    localparam logic [15:0] CRC_POLY = 16'h8408;

    localparam logic [7:0] FUNCTION_CODE_RESET = 8'd103;
    localparam logic [7:0] MAX_PAYLOAD_RESET   = 8'd252;
    localparam logic [7:0] REPLY_FLAG          = 8'h80;

    localparam logic [7:0] FRAME_HEADER [4] = '{8'h02, 8'h00, 8'h00, 8'h01};

    // Header, function code and CRC bytes around the payload
    localparam int FRAME_OVERHEAD = 7;
    localparam int HEADER_LEN     = 4;
    localparam int DELAY_LEN      = 2;

    typedef enum logic {
        CFG_FUNCTION_CODE = 1'b0,
        CFG_MAX_PAYLOAD   = 1'b1
    } t_cfg_index;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SHORT     = 3'd1,
        ST_OVERFLOW  = 3'd2,
        ST_HEADER    = 3'd3,
        ST_CRC       = 3'd4,
        ST_FUNCTION  = 3'd5,
        ST_TOO_LONG  = 3'd6,
        ST_LINE_ERR  = 3'd7
    } t_status;

    typedef enum logic [1:0] {
        EX_NONE     = 2'd0,
        EX_FUNCTION = 2'd1,
        EX_TOO_LONG = 2'd2
    } t_exception;

    typedef struct packed {
        logic       is_status;
        logic [7:0] payload_byte;
        t_status    frame_status;
        logic [7:0] payload_length;
        logic [7:0] reply_code;
        t_exception exception_code;
        logic       last_result;
    } t_result;

    typedef struct packed {
        logic [1:0] count;
        t_result    first;
        t_result    second;
    } t_push;

    typedef struct packed {
        logic       en;
        t_cfg_index index;
        logic [7:0] data;
    } t_cfg_wr;

    function automatic logic [15:0] crc_a_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

/* hdl/nfc_channels.sv */
`timescale 1ns / 1ps

interface nfc_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       end_of_frame;
    logic       line_error;

    modport source (output valid, output rx_byte, output end_of_frame, output line_error,
                    input ready);
    modport sink   (input valid, input rx_byte, input end_of_frame, input line_error,
                    output ready);
endinterface

interface nfc_res_if;
    logic       valid;
    logic       ready;
    logic       is_status;
    logic [7:0] payload_byte;
    logic [2:0] frame_status;
    logic [7:0] payload_length;
    logic [7:0] reply_code;
    logic [1:0] exception_code;
    logic       last_result;

    modport source (output valid, output is_status, output payload_byte, output frame_status,
                    output payload_length, output reply_code, output exception_code,
                    output last_result, input ready);
    modport sink   (input valid, input is_status, input payload_byte, input frame_status,
                    input payload_length, input reply_code, input exception_code,
                    input last_result, output ready);
endinterface

interface nfc_cfg_if;
    logic       valid;
    logic       ready;
    logic       index;
    logic [7:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* hdl/nfc_frame_core.sv */
`timescale 1ns / 1ps

module nfc_frame_core #(
    parameter int FRAME_MAX = nfc_pkg::FRAME_MAX_DEFAULT
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  logic [7:0]      i_rx_byte,
    input  logic            i_end_of_frame,
    input  logic            i_line_error,
    input  nfc_pkg::t_cfg_wr i_cfg,
    output nfc_pkg::t_push  o_push
);

    localparam int CNT_W = $clog2(FRAME_MAX + 1);

    logic [CNT_W-1:0] r_count, n_count;
    logic [15:0]      r_crc, n_crc;
    logic [15:0]      r_delay, n_delay;
    logic             r_header_ok, n_header_ok;
    logic [7:0]       r_rx_func, n_rx_func;
    logic             r_overflow, n_overflow;
    logic             r_error, n_error;
    logic [7:0]       r_function_code;
    logic [7:0]       r_max_payload;

    logic             take;
    logic             pay_v;
    logic [CNT_W-1:0] plen_full;
    logic [15:0]      plen_w;
    nfc_pkg::t_result pay_res, stat_res;

    always_comb begin
        n_count     = r_count;
        n_crc       = r_crc;
        n_delay     = r_delay;
        n_header_ok = r_header_ok;
        n_rx_func   = r_rx_func;
        n_overflow  = r_overflow;
        n_error     = r_error | i_line_error;
        pay_v       = 1'b0;
        take        = !n_error && !r_overflow;

        if (take) begin
            if (r_count >= CNT_W'(FRAME_MAX)) begin
                n_overflow = 1'b1;
            end else begin
                if (r_count >= CNT_W'(nfc_pkg::DELAY_LEN)) begin
                    n_crc = nfc_pkg::crc_a_byte(r_crc, r_delay[15:8]);
                    pay_v = (r_count >= CNT_W'(nfc_pkg::FRAME_OVERHEAD));
                end
                if (r_count < CNT_W'(nfc_pkg::HEADER_LEN) &&
                    i_rx_byte != nfc_pkg::FRAME_HEADER[r_count[1:0]]) begin
                    n_header_ok = 1'b0;
                end
                if (r_count == CNT_W'(nfc_pkg::HEADER_LEN)) begin
                    n_rx_func = i_rx_byte;
                end
                n_delay = {r_delay[7:0], i_rx_byte};
                n_count = r_count + 1'b1;
            end
        end

        // End-of-frame status from the updated frame state
        plen_full = (n_count >= CNT_W'(nfc_pkg::FRAME_OVERHEAD))
                  ? n_count - CNT_W'(nfc_pkg::FRAME_OVERHEAD) : '0;
        plen_w    = 16'(plen_full);

        stat_res                = '0;
        stat_res.is_status      = 1'b1;
        stat_res.last_result    = 1'b1;
        stat_res.payload_length = (plen_w > 16'd255) ? 8'hFF : plen_w[7:0];
        stat_res.frame_status   = nfc_pkg::ST_OK;
        stat_res.exception_code = nfc_pkg::EX_NONE;
        priority if (n_error) begin
            stat_res.frame_status = nfc_pkg::ST_LINE_ERR;
        end else if (n_count < CNT_W'(nfc_pkg::FRAME_OVERHEAD)) begin
            stat_res.frame_status = nfc_pkg::ST_SHORT;
        end else if (n_overflow) begin
            stat_res.frame_status = nfc_pkg::ST_OVERFLOW;
        end else if (!n_header_ok) begin
            stat_res.frame_status = nfc_pkg::ST_HEADER;
        end else if (n_crc[7:0] != n_delay[15:8] || n_crc[15:8] != n_delay[7:0]) begin
            stat_res.frame_status = nfc_pkg::ST_CRC;
        end else if (n_rx_func != r_function_code) begin
            stat_res.frame_status   = nfc_pkg::ST_FUNCTION;
            stat_res.exception_code = nfc_pkg::EX_FUNCTION;
            stat_res.reply_code     = n_rx_func | nfc_pkg::REPLY_FLAG;
        end else if (plen_w > 16'(r_max_payload)) begin
            stat_res.frame_status   = nfc_pkg::ST_TOO_LONG;
            stat_res.exception_code = nfc_pkg::EX_TOO_LONG;
            stat_res.reply_code     = n_rx_func | nfc_pkg::REPLY_FLAG;
        end else begin
            stat_res.frame_status = nfc_pkg::ST_OK;
        end

        pay_res              = '0;
        pay_res.payload_byte = r_delay[15:8];
        pay_res.frame_status = nfc_pkg::ST_OK;
        pay_res.exception_code = nfc_pkg::EX_NONE;
        pay_res.last_result  = !i_end_of_frame;

        o_push = '0;
        if (i_accept) begin
            priority if (pay_v && i_end_of_frame) begin
                o_push.count  = 2'd2;
                o_push.first  = pay_res;
                o_push.second = stat_res;
            end else if (pay_v) begin
                o_push.count = 2'd1;
                o_push.first = pay_res;
            end else if (i_end_of_frame) begin
                o_push.count = 2'd1;
                o_push.first = stat_res;
            end else begin
                o_push.count = 2'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count         <= '0;
            r_crc           <= nfc_pkg::CRC_INIT;
            r_delay         <= '0;
            r_header_ok     <= 1'b1;
            r_rx_func       <= '0;
            r_overflow      <= 1'b0;
            r_error         <= 1'b0;
            r_function_code <= nfc_pkg::FUNCTION_CODE_RESET;
            r_max_payload   <= nfc_pkg::MAX_PAYLOAD_RESET;
        end else begin
            if (i_cfg.en) begin
                unique case (i_cfg.index)
                    nfc_pkg::CFG_FUNCTION_CODE: r_function_code <= i_cfg.data;
                    nfc_pkg::CFG_MAX_PAYLOAD:   r_max_payload   <= i_cfg.data;
                    default: ;
                endcase
            end
            if (i_accept) begin
                if (i_end_of_frame) begin
                    // frame done: back to the idle frame state
                    r_count     <= '0;
                    r_crc       <= nfc_pkg::CRC_INIT;
                    r_delay     <= '0;
                    r_header_ok <= 1'b1;
                    r_rx_func   <= '0;
                    r_overflow  <= 1'b0;
                    r_error     <= 1'b0;
                end else begin
                    r_count     <= n_count;
                    r_crc       <= n_crc;
                    r_delay     <= n_delay;
                    r_header_ok <= n_header_ok;
                    r_rx_func   <= n_rx_func;
                    r_overflow  <= n_overflow;
                    r_error     <= n_error;
                end
            end
        end
    end

endmodule

/* hdl/nfc_result_queue.sv */
`timescale 1ns / 1ps

module nfc_result_queue (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  nfc_pkg::t_push               i_push,
    input  logic                         i_ready,
    output logic                         o_valid,
    output nfc_pkg::t_result             o_head,
    output logic                         o_space,
    output logic [nfc_pkg::LEVEL_W-1:0]  o_level
);

    localparam int DEPTH = nfc_pkg::QUEUE_DEPTH;
    localparam int LW    = nfc_pkg::LEVEL_W;

    nfc_pkg::t_result r_q [DEPTH];
    nfc_pkg::t_result n_q [DEPTH];
    logic [LW-1:0]    r_level, n_level;
    logic [LW-1:0]    remain;
    logic             pop;

    assign pop     = (r_level != '0) && i_ready;
    assign o_valid = (r_level != '0);
    assign o_head  = r_q[0];
    // room for the two words one input can cause
    assign o_space = (r_level <= LW'(DEPTH - 2));
    assign o_level = r_level;

    always_comb begin
        remain = r_level - LW'(pop);
        for (int i = 0; i < DEPTH; i++) begin
            n_q[i] = r_q[i];
        end
        if (pop) begin
            for (int i = 0; i < DEPTH - 1; i++) begin
                n_q[i] = r_q[i + 1];
            end
        end
        for (int i = 0; i < DEPTH; i++) begin
            if (i_push.count != 2'd0 && LW'(i) == remain) begin
                n_q[i] = i_push.first;
            end
            if (i_push.count == 2'd2 && LW'(i) == remain + 1'b1) begin
                n_q[i] = i_push.second;
            end
        end
        n_level = remain + LW'(i_push.count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= '0;
        end else begin
            r_level <= n_level;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < DEPTH; i++) begin
            r_q[i] <= n_q[i];
        end
    end

endmodule

/* hdl/nfc_frame_checker.sv */
`timescale 1ns / 1ps

// NFC command frame checker.
// i_rx takes one received frame byte per word with end_of_frame and line_error.
// o_res gives results: a payload byte (is_status 0) for every byte past the
// header and function code, held back two bytes so the CRC-A trailer is never
// passed on, and one status word (is_status 1) on the final byte of a frame.
// last_result marks the final word caused by one input byte.
// i_cfg writes function_code (index 0) and max_payload (index 1); always ready.
// A result enters the result queue when its byte is taken.
// Throughput: one byte per cycle while the queue has room; the whole CRC byte
// update and the status decision sit between the frame state registers and a
// four-word result queue. The end-of-frame byte can cause two words, but the
// first seven bytes of a frame cause none, so the queue drains and i_rx never
// stalls while the receiver takes one word a cycle.
// i_rx.ready stays high while the queue has two free words, so input keeps
// flowing while a result waits; a stalled receiver fills the queue and then
// holds off i_rx. Reset (synchronous) empties the queue, clears the frame
// state and restores function_code 103 and max_payload 252.
module nfc_frame_checker #(
    parameter int FRAME_MAX = nfc_pkg::FRAME_MAX_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    nfc_rx_if.sink      i_rx,
    nfc_res_if.source   o_res,
    nfc_cfg_if.sink     i_cfg
);

    logic                        accept;
    logic                        space;
    logic [nfc_pkg::LEVEL_W-1:0] level;
    nfc_pkg::t_push              push;
    nfc_pkg::t_result            head;
    nfc_pkg::t_cfg_wr            cfg_wr;

    assign i_cfg.ready  = 1'b1;
    assign cfg_wr.en    = i_cfg.valid;
    assign cfg_wr.index = nfc_pkg::t_cfg_index'(i_cfg.index);
    assign cfg_wr.data  = i_cfg.data;

    assign i_rx.ready = space;
    assign accept     = i_rx.valid && space;

    nfc_frame_core #(
        .FRAME_MAX (FRAME_MAX)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_rx_byte      (i_rx.rx_byte),
        .i_end_of_frame (i_rx.end_of_frame),
        .i_line_error   (i_rx.line_error),
        .i_cfg          (cfg_wr),
        .o_push         (push)
    );

    nfc_result_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_ready (o_res.ready),
        .o_valid (o_res.valid),
        .o_head  (head),
        .o_space (space),
        .o_level (level)
    );

    assign o_res.is_status      = head.is_status;
    assign o_res.payload_byte   = head.payload_byte;
    assign o_res.frame_status   = head.frame_status;
    assign o_res.payload_length = head.payload_length;
    assign o_res.reply_code     = head.reply_code;
    assign o_res.exception_code = head.exception_code;
    assign o_res.last_result    = head.last_result;

`ifndef SYNTHESIS
    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        level <= nfc_pkg::LEVEL_W'(nfc_pkg::QUEUE_DEPTH))
        else $error("result queue overfilled");

    a_eof_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_rx.end_of_frame |=> o_res.valid)
        else $error("end of frame gave no result");

    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_res.valid && !accept |=> !o_res.valid)
        else $error("result appeared without an input byte");
`endif

endmodule

/* tb/nfc_frame_checker_tb.sv */
`timescale 1ns / 1ps

module nfc_frame_checker_tb;

    localparam int FRAME_MAX    = nfc_pkg::FRAME_MAX_DEFAULT;
    localparam int NUM_PHASES   = 5;
    localparam int PHASE_ITEMS  = 40;
    localparam int DRAIN_CYCLES = 6;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int LONG_HOLD    = 100;

    typedef enum logic [1:0] {
        SRC_RAW,
        SRC_CRC_LO,
        SRC_CRC_HI
    } t_byte_src;

    typedef struct packed {
        t_byte_src           src;
        logic [7:0]          value;
        logic                eof;
        logic                lerr;
        logic                typed;
        nfc_pkg::t_status    st;
        logic [7:0]          plen;
        logic [7:0]          reply;
        nfc_pkg::t_exception ex;
    } t_dir_row;

    // Status words typed in where they follow from the frame at a glance
    localparam t_dir_row DIRECTED [25] = '{
        '{SRC_RAW, 8'hFF, 1'b1, 1'b0, 1'b1, nfc_pkg::ST_SHORT, 8'd0, 8'h00, nfc_pkg::EX_NONE},
        '{SRC_RAW, 8'h00, 1'b1, 1'b1, 1'b1, nfc_pkg::ST_LINE_ERR, 8'd0, 8'h00,
          nfc_pkg::EX_NONE},
        '{SRC_RAW, 8'h02, 1'b0, 1'b0, 1'b0, nfc_pkg::ST_OK, 8'd0, 8'h00, nfc_pkg::EX_NONE},
        '{SRC_RAW, 8'h00, 1'b0, 1'b0, 1'b0, nfc_pkg::ST_OK, 8'd0, 8'h00, nfc_pkg::EX_NONE},
        '{SRC_RAW, 8'h00, 1'b0, 1'b0, 1'b0, nfc_pkg::ST_OK, 8'd0, 8'h00, nfc_pkg::EX_NONE},
        '{SRC_RAW, 8'h01, 1'b0, 1'b0, 1'b0, nfc_pkg::ST_OK, 8'd0, 8'h00, nfc_pkg::EX_NONE},
        '{SRC_RAW, nfc_pkg::FUNCTION_CODE_RESET, 1'b0, 1'b0, 1'b0, nfc_pkg::ST_OK, 8'd0,
          8'h00, nfc_pkg::EX_NONE},
        '{SRC_RAW, 8'h00, 1'b0, 1'b0, 1'b0, nfc_pkg::ST_OK, 8'd0, 8'h00, nfc_pkg::EX_NONE},
        '{SRC_RAW, 8'hFF, 1'b0, 1'b0, 1'b0, nfc_pkg::ST_OK, 8'd0, 8'h00, nfc_pkg::EX_NONE},
        '{SRC_CRC_LO, 8'h00, 1'b0, 1'b0, 1'b0, nfc_pkg::ST_OK, 8'd0, 8'h00,
          nfc_pkg::EX_NONE},
        '{SRC_CRC_HI, 8'h00, 1'b1, 1'b0, 1'b1, nfc_pkg::ST_OK, 8'd2, 8'h00,
          nfc_pkg::EX_NONE},
        '{SRC_RAW, 8'h02, 1'b0, 1'b0, 1'b0, nfc_pkg::ST_OK, 8'd0, 8'h00, nfc_pkg::EX_NONE},
        '{SRC_RAW, 8'h00, 1'b0, 1'b0, 1'b0, nfc_pkg::ST_OK, 8'd0, 8'h00, nfc_pkg::EX_NONE},
        '{SRC_RAW, 8'h01, 1'b0, 1'b0, 1'b0, nfc_pkg::ST_OK, 8'd0, 8'h00, nfc_pkg::EX_NONE},
        '{SRC_RAW, 8'h01, 1'b0, 1'b0, 1'b0, nfc_pkg::ST_OK, 8'd0, 8'h00, nfc_pkg::EX_NONE},
        '{SRC_RAW, nfc_pkg::FUNCTION_CODE_RESET, 1'b0, 1'b0, 1'b0, nfc_pkg::ST_OK, 8'd0,
          8'h00, nfc_pkg::EX_NONE},
        '{SRC_CRC_LO, 8'h00, 1'b0, 1'b0, 1'b0, nfc_pkg::ST_OK, 8'd0, 8'h00,
          nfc_pkg::EX_NONE},
        '{SRC_CRC_HI, 8'h00, 1'b1, 1'b0, 1'b1, nfc_pkg::ST_HEADER, 8'd0, 8'h00,
          nfc_pkg::EX_NONE},
        '{SRC_RAW, 8'h02, 1'b0, 1'b0, 1'b0, nfc_pkg::ST_OK, 8'd0, 8'h00, nfc_pkg::EX_NONE},
        '{SRC_RAW, 8'h00, 1'b0, 1'b0, 1'b0, nfc_pkg::ST_OK, 8'd0, 8'h00, nfc_pkg::EX_NONE},
        '{SRC_RAW, 8'h00, 1'b0, 1'b0, 1'b0, nfc_pkg::ST_OK, 8'd0, 8'h00, nfc_pkg::EX_NONE},
        '{SRC_RAW, 8'h01, 1'b0, 1'b0, 1'b0, nfc_pkg::ST_OK, 8'd0, 8'h00, nfc_pkg::EX_NONE},
        '{SRC_RAW, 8'h66, 1'b0, 1'b0, 1'b0, nfc_pkg::ST_OK, 8'd0, 8'h00, nfc_pkg::EX_NONE},
        '{SRC_CRC_LO, 8'h00, 1'b0, 1'b0, 1'b0, nfc_pkg::ST_OK, 8'd0, 8'h00,
          nfc_pkg::EX_NONE},
        '{SRC_CRC_HI, 8'h00, 1'b1, 1'b0, 1'b1, nfc_pkg::ST_FUNCTION, 8'd0, 8'hE6,
          nfc_pkg::EX_FUNCTION}
    };

    logic i_clk;
    logic i_rst_n;

    nfc_rx_if  rx ();
    nfc_res_if res ();
    nfc_cfg_if cfg ();

    nfc_frame_checker #(
        .FRAME_MAX (FRAME_MAX)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx),
        .o_res   (res),
        .i_cfg   (cfg)
    );

    // Register copies and frame state of the predictor
    logic [7:0]  cfg_function;
    logic [7:0]  cfg_max_payload;
    logic [8:0]  frm_taken;
    logic [15:0] crc_acc;
    logic [15:0] pipe2;
    logic        hdr_good;
    logic [7:0]  got_func;
    logic        frm_overflow;
    logic        frm_aborted;

    nfc_pkg::t_result awaited_words [$];
    logic [7:0]       frame_bytes [$];
    logic             frame_lerr [$];

    int          mismatch_count = 0;
    int          words_taken    = 0;
    int          items_sent     = 0;
    int          cycle_count    = 0;
    bit          tx_burst       = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [15:0] crc_a_update(input logic [15:0] c, input logic [7:0] d);
        logic fb;
        for (int i = 0; i < 8; i++) begin
            fb = c[0] ^ d[i];
            c  = c >> 1;
            if (fb) begin
                c = c ^ nfc_pkg::CRC_POLY;
            end
        end
        return c;
    endfunction

    function automatic void clear_frame_state();
        frm_taken    = '0;
        crc_acc      = nfc_pkg::CRC_INIT;
        pipe2        = '0;
        hdr_good     = 1'b1;
        got_func     = '0;
        frm_overflow = 1'b0;
        frm_aborted  = 1'b0;
    endfunction

    function automatic void predict_results_for_byte(input logic [7:0] b, input logic eof,
                                                     input logic lerr, input logic typed,
                                                     input nfc_pkg::t_result given);
        nfc_pkg::t_result pay_w;
        nfc_pkg::t_result stat_w;
        logic             has_pay;
        logic [8:0]       plen;
        has_pay = 1'b0;
        pay_w   = '0;
        stat_w  = '0;
        if (lerr) begin
            frm_aborted = 1'b1;
        end
        if (!frm_aborted && !frm_overflow) begin
            if (frm_taken >= FRAME_MAX) begin
                frm_overflow = 1'b1;
            end else begin
                // the byte leaving the delay line joins the CRC
                if (frm_taken >= nfc_pkg::DELAY_LEN) begin
                    crc_acc = crc_a_update(crc_acc, pipe2[15:8]);
                    if (frm_taken >= nfc_pkg::FRAME_OVERHEAD) begin
                        pay_w.payload_byte = pipe2[15:8];
                        has_pay            = 1'b1;
                    end
                end
                if (frm_taken < nfc_pkg::HEADER_LEN &&
                    b != nfc_pkg::FRAME_HEADER[frm_taken[1:0]]) begin
                    hdr_good = 1'b0;
                end
                if (frm_taken == nfc_pkg::HEADER_LEN) begin
                    got_func = b;
                end
                pipe2     = {pipe2[7:0], b};
                frm_taken = frm_taken + 9'd1;
            end
        end
        if (eof) begin
            plen = (frm_taken >= 9'(nfc_pkg::FRAME_OVERHEAD))
                 ? frm_taken - 9'(nfc_pkg::FRAME_OVERHEAD) : 9'd0;
            if (plen > 9'd255) begin
                plen = 9'd255;
            end
            stat_w.is_status      = 1'b1;
            stat_w.payload_length = plen[7:0];
            stat_w.frame_status   = nfc_pkg::ST_OK;
            stat_w.exception_code = nfc_pkg::EX_NONE;
            if (frm_aborted) begin
                stat_w.frame_status = nfc_pkg::ST_LINE_ERR;
            end else if (frm_taken < nfc_pkg::FRAME_OVERHEAD) begin
                stat_w.frame_status = nfc_pkg::ST_SHORT;
            end else if (frm_overflow) begin
                stat_w.frame_status = nfc_pkg::ST_OVERFLOW;
            end else if (!hdr_good) begin
                stat_w.frame_status = nfc_pkg::ST_HEADER;
            end else if (crc_acc != {pipe2[7:0], pipe2[15:8]}) begin
                stat_w.frame_status = nfc_pkg::ST_CRC;
            end else if (got_func != cfg_function) begin
                stat_w.frame_status   = nfc_pkg::ST_FUNCTION;
                stat_w.exception_code = nfc_pkg::EX_FUNCTION;
                stat_w.reply_code     = got_func | nfc_pkg::REPLY_FLAG;
            end else if (plen > cfg_max_payload) begin
                stat_w.frame_status   = nfc_pkg::ST_TOO_LONG;
                stat_w.exception_code = nfc_pkg::EX_TOO_LONG;
                stat_w.reply_code     = got_func | nfc_pkg::REPLY_FLAG;
            end
            if (typed) begin
                stat_w.frame_status   = given.frame_status;
                stat_w.payload_length = given.payload_length;
                stat_w.reply_code     = given.reply_code;
                stat_w.exception_code = given.exception_code;
            end
            stat_w.last_result = 1'b1;
            clear_frame_state();
        end else begin
            pay_w.last_result = 1'b1;
        end
        if (has_pay) begin
            awaited_words.push_back(pay_w);
        end
        if (eof) begin
            awaited_words.push_back(stat_w);
        end
    endfunction

    function automatic void check_field(input string field, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", field, want, got);
            mismatch_count++;
        end
    endfunction

    function automatic void take_result_word();
        nfc_pkg::t_result exp_w;
        words_taken++;
        if (awaited_words.size() == 0) begin
            $error("result word with none expected: is_status %0b, payload_byte %0h",
                   res.is_status, res.payload_byte);
            mismatch_count++;
        end else begin
            exp_w = awaited_words.pop_front();
            check_field("is_status", exp_w.is_status, res.is_status);
            check_field("payload_byte", exp_w.payload_byte, res.payload_byte);
            check_field("frame_status", exp_w.frame_status, res.frame_status);
            check_field("payload_length", exp_w.payload_length, res.payload_length);
            check_field("reply_code", exp_w.reply_code, res.reply_code);
            check_field("exception_code", exp_w.exception_code, res.exception_code);
            check_field("last_result", exp_w.last_result, res.last_result);
        end
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 45);
    endfunction

    task automatic send_word(input logic [7:0] b, input logic eof, input logic lerr,
                             input logic typed, input nfc_pkg::t_result given);
        int gap;
        if ($urandom_range(0, 39) == 0) begin
            tx_burst = !tx_burst;
        end
        gap = tx_burst ? 0 : pick_gap();
        if (gap > 0) begin
            rx.valid   <= 1'b0;
            rx.rx_byte <= 8'($urandom);
            repeat (gap) @(posedge i_clk);
        end
        rx.valid        <= 1'b1;
        rx.rx_byte      <= b;
        rx.end_of_frame <= eof;
        rx.line_error   <= lerr;
        @(posedge i_clk);
        while (rx.ready !== 1'b1) @(posedge i_clk);
        predict_results_for_byte(b, eof, lerr, typed, given);
        items_sent++;
    endtask

    task automatic write_reg(input nfc_pkg::t_cfg_index idx, input logic [7:0] val);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= val;
        @(posedge i_clk);
        while (cfg.ready !== 1'b1) @(posedge i_clk);
        if (idx == nfc_pkg::CFG_FUNCTION_CODE) begin
            cfg_function = val;
        end else begin
            cfg_max_payload = val;
        end
    endtask

    task automatic wait_drained();
        while (awaited_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_directed();
        logic [15:0]      c;
        logic [7:0]       b;
        nfc_pkg::t_result given;
        c = nfc_pkg::CRC_INIT;
        foreach (DIRECTED[i]) begin
            case (DIRECTED[i].src)
                SRC_CRC_LO: b = c[7:0];
                SRC_CRC_HI: b = c[15:8];
                default: begin
                    b = DIRECTED[i].value;
                    c = crc_a_update(c, b);
                end
            endcase
            given                = '0;
            given.frame_status   = DIRECTED[i].st;
            given.payload_length = DIRECTED[i].plen;
            given.reply_code     = DIRECTED[i].reply;
            given.exception_code = DIRECTED[i].ex;
            send_word(b, DIRECTED[i].eof, DIRECTED[i].lerr, DIRECTED[i].typed, given);
            if (DIRECTED[i].eof) begin
                c = nfc_pkg::CRC_INIT;
            end
        end
    endtask

    function automatic void build_good_frame(input logic [7:0] fn, input int plen);
        logic [15:0] c;
        frame_bytes.delete();
        frame_lerr.delete();
        for (int i = 0; i < nfc_pkg::HEADER_LEN; i++) begin
            frame_bytes.push_back(nfc_pkg::FRAME_HEADER[i]);
        end
        frame_bytes.push_back(fn);
        for (int i = 0; i < plen; i++) begin
            frame_bytes.push_back(8'($urandom));
        end
        c = nfc_pkg::CRC_INIT;
        foreach (frame_bytes[i]) begin
            c = crc_a_update(c, frame_bytes[i]);
        end
        frame_bytes.push_back(c[7:0]);
        frame_bytes.push_back(c[15:8]);
        foreach (frame_bytes[i]) begin
            frame_lerr.push_back(1'b0);
        end
    endfunction

    task automatic send_frame();
        for (int i = 0; i < frame_bytes.size(); i++) begin
            send_word(frame_bytes[i], i == frame_bytes.size() - 1, frame_lerr[i], 1'b0, '0);
        end
    endtask

    task automatic send_random_frame();
        int         kind;
        int         n;
        int         pos;
        int         plen;
        int         lo;
        logic [7:0] fn;
        kind = $urandom_range(0, 99);
        fn   = ($urandom_range(0, 4) != 0) ? cfg_function : 8'($urandom);
        // hover around the payload limit when it is small
        if (cfg_max_payload <= 20 && $urandom_range(0, 2) == 0) begin
            lo   = (cfg_max_payload > 2) ? cfg_max_payload - 2 : 0;
            plen = $urandom_range(lo, cfg_max_payload + 2);
        end else if ($urandom_range(0, 4) == 0) begin
            plen = $urandom_range(11, 40);
        end else begin
            plen = $urandom_range(0, 10);
        end
        build_good_frame(fn, plen);
        if (kind < 60) begin
            // well formed
        end else if (kind < 72) begin
            pos = $urandom_range(0, frame_bytes.size() - 1);
            frame_bytes[pos] ^= 8'(1 << $urandom_range(0, 7));
        end else if (kind < 82) begin
            pos = $urandom_range(0, frame_bytes.size() - 1);
            frame_lerr[pos] = 1'b1;
        end else if (kind < 90) begin
            n = $urandom_range(1, 6);
            while (frame_bytes.size() > n) begin
                void'(frame_bytes.pop_back());
                void'(frame_lerr.pop_back());
            end
        end else begin
            frame_bytes.delete();
            frame_lerr.delete();
            n = $urandom_range(1, 20);
            repeat (n) begin
                frame_bytes.push_back(8'($urandom));
                frame_lerr.push_back($urandom_range(0, 9) == 0);
            end
        end
        send_frame();
    endtask

    // Result side: random stalls, plus one long hold-off to back the block up
    initial begin : result_sink
        int stall_left;
        int hold_left;
        bit rx_burst;
        bit long_done;
        stall_left = 0;
        hold_left  = 0;
        rx_burst   = 1'b0;
        long_done  = 1'b0;
        res.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (res.valid === 1'b1 && res.ready === 1'b1) begin
                take_result_word();
            end
            if (!long_done && words_taken == 200) begin
                hold_left = LONG_HOLD;
                long_done = 1'b1;
            end
            if ($urandom_range(0, 59) == 0) begin
                rx_burst = !rx_burst;
            end
            if (hold_left > 0) begin
                hold_left--;
                res.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                res.ready <= 1'b0;
            end else begin
                res.ready <= 1'b1;
                if (!rx_burst && $urandom_range(0, 3) == 0) begin
                    stall_left = pick_gap();
                end
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("== FAIL ==");
        $finish;
    end

    initial begin : stimulus
        logic [7:0] fn;
        logic [7:0] mx;
        int         phase_start;
        cfg_function    = nfc_pkg::FUNCTION_CODE_RESET;
        cfg_max_payload = nfc_pkg::MAX_PAYLOAD_RESET;
        clear_frame_state();
        i_rst_n         <= 1'b0;
        rx.valid        <= 1'b0;
        rx.rx_byte      <= 8'h00;
        rx.end_of_frame <= 1'b0;
        rx.line_error   <= 1'b0;
        cfg.valid       <= 1'b0;
        cfg.index       <= nfc_pkg::CFG_FUNCTION_CODE;
        cfg.data        <= 8'h00;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();

        for (int p = 0; p < NUM_PHASES; p++) begin
            // hold the sender until every result is in, then retune the registers
            rx.valid <= 1'b0;
            wait_drained();
            case (p)
                0: begin
                    fn = nfc_pkg::FUNCTION_CODE_RESET;
                    mx = nfc_pkg::MAX_PAYLOAD_RESET;
                end
                1: begin
                    fn = 8'h00;
                    mx = 8'd0;
                end
                2: begin
                    fn = 8'hFF;
                    mx = 8'd3;
                end
                3: begin
                    fn = 8'($urandom);
                    mx = 8'($urandom_range(0, 252));
                end
                default: begin
                    fn = 8'h5A;
                    mx = 8'd252;
                end
            endcase
            if (p % 2 == 0) begin
                write_reg(nfc_pkg::CFG_FUNCTION_CODE, fn);
                write_reg(nfc_pkg::CFG_MAX_PAYLOAD, mx);
            end else begin
                write_reg(nfc_pkg::CFG_MAX_PAYLOAD, mx);
                write_reg(nfc_pkg::CFG_FUNCTION_CODE, fn);
            end
            cfg.valid <= 1'b0;

            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS) begin
                send_random_frame();
            end
            // longest legal frame, then one that runs past the limit
            if (p == 0) begin
                build_good_frame(cfg_function, FRAME_MAX - nfc_pkg::FRAME_OVERHEAD);
                send_frame();
            end else if (p == 1) begin
                build_good_frame(cfg_function, FRAME_MAX - nfc_pkg::FRAME_OVERHEAD);
                repeat ($urandom_range(1, 3)) begin
                    frame_bytes.push_back(8'($urandom));
                    frame_lerr.push_back(1'b0);
                end
                send_frame();
            end
        end

        rx.valid <= 1'b0;
        wait_drained();
        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
